// ===== rtl/core/tbrl_pkg.sv =====
// Shared types, widths, reset values and helpers for the token bucket limiter.
// Used by tbrl_regs, tbrl_core and token_bucket_rate_limiter. No dependencies.
`timescale 1ns / 1ps

package tbrl_pkg;

  localparam int REQ_W   = 2;
  localparam int MS_W    = 10;
  localparam int RATE_W  = 24;
  localparam int BURST_W = 16;
  localparam int TOK_W   = 32;
  localparam int CNT_W   = 32;
  localparam int PROD_W  = MS_W + RATE_W;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd6554;
  localparam logic [BURST_W-1:0] BURST_RESET = 16'd10;

  // Request codes; code three is unused and leaves the state alone.
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_ACQUIRE = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_t;

  // Register index, taken from address bit 2 (byte address 4*i).
  typedef enum logic {
    REG_RATE  = 1'b0,
    REG_BURST = 1'b1
  } reg_idx_t;

  // Configuration handed from the register file to the datapath.
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [TOK_W-1:0]  cap;
    logic              clamp;
    logic [TOK_W-1:0]  clamp_cap;
  } cfg_t;

  // Bucket capacity: burst in whole tokens shifted into fixed point,
  // saturated to the all-ones token value when it does not fit.
  function automatic logic [TOK_W-1:0] cap_of(input logic [BURST_W-1:0] burst,
                                               input int frac);
    logic [63:0] wide;
    wide = 64'(burst) << frac;
    if (wide[63:TOK_W] != '0) begin
      return '1;
    end
    return wide[TOK_W-1:0];
  endfunction

endpackage

// ===== rtl/core/token_bucket_rate_limiter.sv =====
// Token bucket rate limiter, Q16.16 by default, with an APB register port.
// An accepted beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_ready is high; an empty input stage
// takes a beat while a result waits. The refill multiply is registered ahead
// of the bucket update. Synchronous active-high reset: bucket full at the
// reset burst limit, not limited, rejected count zero, pipeline empty.
`timescale 1ns / 1ps

module token_bucket_rate_limiter
  import tbrl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [MS_W-1:0]   elapsed_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              granted,
  output logic              limit_exceeded,
  output logic              limit_released,
  output logic              limited,
  output logic [TOK_W-1:0]  tokens_available,
  output logic [CNT_W-1:0]  rejected_total
);

  cfg_t cfg;

  // Configuration registers.
  tbrl_regs #(
    .FRAC_BITS(FRAC_BITS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // Bucket datapath.
  tbrl_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .elapsed_ms      (elapsed_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted         (granted),
    .limit_exceeded  (limit_exceeded),
    .limit_released  (limit_released),
    .limited         (limited),
    .tokens_available(tokens_available),
    .rejected_total  (rejected_total)
  );

endmodule

// ===== rtl/core/tbrl_regs.sv =====
// APB register file for the limiter: refill rate and burst limit.
// Depends on tbrl_pkg; produces the cfg_t struct for tbrl_core.
`timescale 1ns / 1ps

module tbrl_regs
  import tbrl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [RATE_W-1:0]  rate;
  logic [BURST_W-1:0] burst;
  logic               wr_en;
  reg_idx_t           idx;
  logic [RATE_W-1:0]  wr_rate;
  logic [BURST_W-1:0] wr_burst;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign idx      = reg_idx_t'(paddr[2]);
  assign wr_rate  = pwdata[RATE_W-1:0];
  assign wr_burst = pwdata[BURST_W-1:0];

  // Register writes; a zero value is ignored for both registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate  <= RATE_RESET;
      burst <= BURST_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_RATE: begin
          if (wr_rate != '0) rate <= wr_rate;
        end
        REG_BURST: begin
          if (wr_burst != '0) burst <= wr_burst;
        end
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    unique case (idx)
      REG_RATE:  prdata = DATA_W'(rate);
      REG_BURST: prdata = DATA_W'(burst);
    endcase
  end

  // Configuration to the datapath, with a clamp strobe on a nonzero burst write.
  always_comb begin
    cfg.rate      = rate;
    cfg.cap       = cap_of(burst, FRAC_BITS);
    cfg.clamp     = wr_en && (idx == REG_BURST) && (wr_burst != '0);
    cfg.clamp_cap = cap_of(wr_burst, FRAC_BITS);
  end

endmodule

// ===== rtl/core/tbrl_core.sv =====
// Bucket datapath: input stage with the refill product, then the bucket
// update into the result register. Depends on tbrl_pkg, which defines cfg_t.
`timescale 1ns / 1ps

module tbrl_core
  import tbrl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [MS_W-1:0]   elapsed_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              granted,
  output logic              limit_exceeded,
  output logic              limit_released,
  output logic              limited,
  output logic [TOK_W-1:0]  tokens_available,
  output logic [CNT_W-1:0]  rejected_total
);

  localparam logic [TOK_W-1:0] ONE = TOK_W'(1) << FRAC_BITS;

  // Input stage.
  logic              s1_valid;
  logic [REQ_W-1:0]  s1_req;
  logic [PROD_W-1:0] s1_prod;

  // Bucket state.
  logic [TOK_W-1:0] tokens;
  logic [TOK_W-1:0] tokens_next;
  logic             lim;
  logic             lim_next;
  logic [CNT_W-1:0] rejected;
  logic [CNT_W-1:0] rejected_next;
  logic             grant_next;
  logic             exceed_next;
  logic             release_next;

  logic             out_adv;
  logic             s1_fire;
  logic [PROD_W:0]  sum;

  assign out_adv  = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_adv;
  assign in_ready = !s1_valid || out_adv;

  // Input register: the refill product is formed here, a beat ahead.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_req  <= req_type;
      s1_prod <= PROD_W'(elapsed_ms) * PROD_W'(cfg.rate);
    end
  end

  assign sum = (PROD_W + 1)'(tokens) + (PROD_W + 1)'(s1_prod);

  // Bucket update for the beat leaving the input stage.
  always_comb begin
    tokens_next   = tokens;
    lim_next      = lim;
    rejected_next = rejected;
    grant_next    = 1'b0;
    exceed_next   = 1'b0;
    release_next  = 1'b0;
    unique case (s1_req)
      REQ_TICK: begin
        if (s1_prod != '0) begin
          tokens_next = (sum > (PROD_W + 1)'(cfg.cap)) ? cfg.cap : sum[TOK_W-1:0];
        end
      end
      REQ_ACQUIRE: begin
        if (tokens >= ONE) begin
          tokens_next = tokens - ONE;
          grant_next  = 1'b1;
          if (lim) begin
            lim_next     = 1'b0;
            release_next = 1'b1;
          end
        end else begin
          tokens_next = '0;
          if (rejected != '1) rejected_next = rejected + CNT_W'(1);
          if (!lim) begin
            lim_next    = 1'b1;
            exceed_next = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        rejected_next = '0;
      end
      default: begin
        // Unused code: state is reported unchanged.
      end
    endcase
  end

  // State registers; a burst write clamps the bucket when no beat updates it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tokens   <= cap_of(BURST_RESET, FRAC_BITS);
      lim      <= 1'b0;
      rejected <= '0;
    end else if (s1_fire) begin
      tokens   <= tokens_next;
      lim      <= lim_next;
      rejected <= rejected_next;
    end else if (cfg.clamp && (tokens > cfg.clamp_cap)) begin
      tokens <= cfg.clamp_cap;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
    if (s1_fire) begin
      granted          <= grant_next;
      limit_exceeded   <= exceed_next;
      limit_released   <= release_next;
      limited          <= lim_next;
      tokens_available <= tokens_next;
      rejected_total   <= rejected_next;
    end
  end

endmodule

// ===== sim/tb_token_bucket_rate_limiter.sv =====
// Self-checking testbench for token_bucket_rate_limiter: directed and random request beats
// are scored against a cycle-free bucket predictor under random input gaps and output stalls.
// Depends on rtl/core/tbrl_pkg.sv and rtl/core/token_bucket_rate_limiter.sv.
`timescale 1ns / 1ps

module tb_token_bucket_rate_limiter;
  import tbrl_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam int IDLE_PAUSE = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_MAX = 10;
  // Request code three has no package name; it must leave the state alone.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic             granted;
    logic             exceeded;
    logic             released;
    logic             limited;
    logic [TOK_W-1:0] tokens;
    logic [CNT_W-1:0] rejected;
  } bucket_result_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type;
  logic [MS_W-1:0]   elapsed_ms;
  logic              out_valid;
  logic              out_ready;
  logic              granted;
  logic              limit_exceeded;
  logic              limit_released;
  logic              limited;
  logic [TOK_W-1:0]  tokens_available;
  logic [CNT_W-1:0]  rejected_total;

  // Predicted bucket state and register copies.
  logic [RATE_W-1:0]  rate_q;
  logic [BURST_W-1:0] burst_q;
  logic [TOK_W-1:0]   bucket_q;
  logic               limited_q;
  logic [CNT_W-1:0]   rejected_q;

  bucket_result_t expected_results[$];
  int mismatch_count;
  int hold_asks;

  token_bucket_rate_limiter #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .elapsed_ms      (elapsed_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted         (granted),
    .limit_exceeded  (limit_exceeded),
    .limit_released  (limit_released),
    .limited         (limited),
    .tokens_available(tokens_available),
    .rejected_total  (rejected_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bucket capacity in fixed point, saturated when the shift overflows 32 bits.
  function automatic logic [TOK_W-1:0] bucket_capacity();
    logic [63:0] wide;
    wide = 64'(burst_q) << FRAC;
    return (wide > 64'hFFFF_FFFF) ? '1 : wide[TOK_W-1:0];
  endfunction

  // Register write as seen by the bucket; zero values are dropped.
  function automatic void apply_register(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    logic [TOK_W-1:0] cap;
    case (idx)
      REG_RATE: begin
        if (data[RATE_W-1:0] != '0) rate_q = data[RATE_W-1:0];
      end
      REG_BURST: begin
        if (data[BURST_W-1:0] != '0) begin
          burst_q = data[BURST_W-1:0];
          cap = bucket_capacity();
          if (bucket_q > cap) bucket_q = cap;
        end
      end
      default: ;
    endcase
  endfunction

  // Advances the predicted bucket by one request beat and returns its result.
  function automatic bucket_result_t predict_beat(input logic [REQ_W-1:0] req,
                                                  input logic [MS_W-1:0] ms);
    bucket_result_t r;
    logic [63:0]    sum;
    logic [TOK_W-1:0] cap;
    logic [TOK_W-1:0] one_token;
    r = '0;
    one_token = TOK_W'(1) << FRAC;
    case (req)
      REQ_TICK: begin
        if (ms != '0) begin
          sum = 64'(bucket_q) + 64'(ms) * 64'(rate_q);
          cap = bucket_capacity();
          bucket_q = (sum > 64'(cap)) ? cap : sum[TOK_W-1:0];
        end
      end
      REQ_ACQUIRE: begin
        if (bucket_q >= one_token) begin
          bucket_q = bucket_q - one_token;
          r.granted = 1'b1;
          if (limited_q) begin
            limited_q = 1'b0;
            r.released = 1'b1;
          end
        end else begin
          // Refusal drains the bucket and counts, saturating.
          bucket_q = '0;
          if (rejected_q != '1) rejected_q = rejected_q + 1'b1;
          if (!limited_q) begin
            limited_q = 1'b1;
            r.exceeded = 1'b1;
          end
        end
      end
      REQ_CLEAR: rejected_q = '0;
      default: ;
    endcase
    r.limited = limited_q;
    r.tokens = bucket_q;
    r.rejected = rejected_q;
    return r;
  endfunction

  // Offers one request beat and records its expected result on acceptance.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [MS_W-1:0] ms);
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= req;
    elapsed_ms <= ms;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_beat(req, ms));
  endtask

  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stops offering beats and waits until every expected result has been seen.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Setup and access phases; the register takes the value on the access edge.
  task automatic config_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One random beat: mostly acquires and ticks, a few clears and unused codes.
  task automatic random_beat(input int acquire_pct);
    int roll;
    logic [REQ_W-1:0] req;
    logic [MS_W-1:0] ms;
    roll = $urandom_range(0, 99);
    if (roll < acquire_pct) req = REQ_ACQUIRE;
    else if (roll < acquire_pct + 5) req = REQ_CLEAR;
    else if (roll < acquire_pct + 8) req = REQ_UNUSED;
    else req = REQ_TICK;
    roll = $urandom_range(0, 99);
    if (roll < 15) ms = '0;
    else if (roll < 25) ms = '1;
    else if (roll < 50) ms = MS_W'($urandom_range(1, 8));
    else ms = MS_W'($urandom);
    send_item(req, ms);
  endtask

  // Reset values: drain a full bucket, get limited, recover through a tick.
  task automatic test_bucket_basics();
    send_item(REQ_TICK, '0);
    repeat (10) send_item(REQ_ACQUIRE, MS_W'($urandom));
    send_item(REQ_ACQUIRE, '0);
    send_item(REQ_ACQUIRE, '1);
    send_item(REQ_UNUSED, MS_W'(500));
    send_item(REQ_CLEAR, '1);
    send_item(REQ_ACQUIRE, '0);
    send_item(REQ_TICK, '1);
    send_item(REQ_ACQUIRE, '0);
    send_item(REQ_ACQUIRE, '0);
    send_item(REQ_TICK, MS_W'(1));
    send_item(REQ_TICK, MS_W'(341));
    send_item(REQ_TICK, MS_W'(682));
  endtask

  // Register extremes, ignored zero writes, masking of upper data bits and clamping.
  task automatic test_register_extremes();
    config_write(REG_RATE, 32'h00FF_FFFF);
    config_write(REG_BURST, 32'h0000_FFFF);
    send_item(REQ_TICK, '1);
    send_item(REQ_ACQUIRE, '0);
    config_write(REG_RATE, 32'hFF00_0000);
    config_write(REG_BURST, 32'hFFFF_0000);
    send_item(REQ_TICK, MS_W'(1));
    config_write(REG_BURST, 32'hABCD_0001);
    send_item(REQ_ACQUIRE, '0);
    send_item(REQ_ACQUIRE, '0);
    config_write(REG_RATE, 32'hAB00_0001);
    send_item(REQ_TICK, '1);
    send_item(REQ_ACQUIRE, '0);
    config_write(REG_BURST, 32'h1234_0003);
    send_item(REQ_TICK, MS_W'(1));
    send_item(REQ_ACQUIRE, '0);
  endtask

  // Random beats in bursts with random gaps under one register setting.
  task automatic test_random_phase(input logic [RATE_W-1:0] rate, input logic [BURST_W-1:0] burst,
                                   input int beats, input int acquire_pct);
    int sent;
    int burst_len;
    config_write(REG_RATE, {8'($urandom), rate});
    config_write(REG_BURST, {16'($urandom), burst});
    sent = 0;
    while (sent < beats) begin
      burst_len = $urandom_range(1, 24);
      for (int k = 0; k < burst_len && sent < beats; k++) begin
        random_beat(acquire_pct);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  // Long output stall while beats keep coming, so the block backs up its input.
  task automatic test_output_backpressure();
    wait_idle();
    hold_asks++;
    repeat (48) random_beat(50);
    wait_idle();
  endtask

  // Receiver: rotating random ready patterns, with an occasional long hold-off.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    int pattern_age;
    logic [15:0] pattern;
    out_ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    pattern_age = 0;
    pattern = '1;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          pattern = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
          pattern_age = $urandom_range(16, 96);
        end
        pattern_age--;
        out_ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  // Result scoreboard: each output beat against the oldest prediction.
  always @(posedge clk) begin
    bucket_result_t got;
    bucket_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{granted, limit_exceeded, limit_released, limited, tokens_available,
              rejected_total};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: result beat with no request pending: tok=%h rej=%0d", $realtime,
                   got.tokens, got.rejected);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: mismatch want g=%0b x=%0b r=%0b l=%0b tok=%h rej=%0d, got g=%0b x=%0b r=%0b l=%0b tok=%h rej=%0d",
                     $realtime, want.granted, want.exceeded, want.released, want.limited,
                     want.tokens, want.rejected, got.granted, got.exceeded, got.released,
                     got.limited, got.tokens, got.rejected);
        end
      end
    end
  end

  // Watchdog: too many cycles without any accepted request beat, result beat or register write.
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    req_type = REQ_TICK;
    elapsed_ms = '0;
    mismatch_count = 0;
    hold_asks = 0;
    rate_q = RATE_RESET;
    burst_q = BURST_RESET;
    bucket_q = bucket_capacity();
    limited_q = 1'b0;
    rejected_q = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bucket_basics();
    test_register_extremes();
    test_random_phase(24'($urandom_range(64, 1023)), 16'd4, 250, 55);
    test_random_phase(24'd1, 16'd1, 250, 45);
    test_random_phase(24'hFF_FFFF, 16'hFFFF, 250, 60);
    test_output_backpressure();
    test_random_phase(24'($urandom_range(1, 24'hFF_FFFF)), 16'($urandom_range(1, 16'hFFFF)),
                      250, 55);
    test_random_phase(24'($urandom_range(1, 4095)), 16'($urandom_range(1, 64)), 250, 55);
    test_random_phase(RATE_RESET, BURST_RESET, 250, 50);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tbrl_pkg.sv
rtl/core/tbrl_regs.sv
rtl/core/tbrl_core.sv
rtl/core/token_bucket_rate_limiter.sv
sim/tb_token_bucket_rate_limiter.sv
